### rtl/mps_pkg.sv
package mps_pkg;

  localparam int LIMB_BITS = 64;
  localparam int MAX_LIMBS = 3;
  localparam int MOD_BITS  = LIMB_BITS * MAX_LIMBS;
  localparam int LIMBS_W   = 2;
  localparam int STATUS_W  = 2;
  // Doubling steps per item: 2 * LIMB_BITS per limb
  localparam int STEP_SHIFT = $clog2(2 * LIMB_BITS);
  localparam int CNT_W      = $clog2(2 * LIMB_BITS * MAX_LIMBS + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_WIDE = 2'd1,
    ST_EVEN = 2'd2
  } mps_status_t;

  typedef struct packed {
    logic               start;
    logic [LIMBS_W-1:0] limbs;
  } mps_cmd_t;

endpackage

### rtl/montgomery_parameter_setup_top.sv
// Channel   Direction  Handshake        Payload
// in_       input      in_valid/stall   modulus limbs 0..2, oversize
// out_      output     out_valid/stall  status, limbs_used, neg_inverse, rsq limbs 0..2
//
// An odd modulus goes from accept through the bit-serial doubling loop, one bit per
// cycle, and then to out_valid. The inverse is found one bit per cycle at the start
// of that loop, one bit for each bit of the low limb. Too-wide or even moduli skip
// the loop and go straight to the finish state. Reset (rst_n, synchronous) clears
// control only. in_stall is high from accept until the item moves to the output
// register, which holds while out_stall is high; the next item can start meanwhile.
module montgomery_parameter_setup_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mps_pkg::LIMB_BITS-1:0]    in_modulus_limb0,
  input  logic [mps_pkg::LIMB_BITS-1:0]    in_modulus_limb1,
  input  logic [mps_pkg::LIMB_BITS-1:0]    in_modulus_limb2,
  input  logic                             in_oversize,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mps_pkg::STATUS_W-1:0]     out_status,
  output logic [mps_pkg::LIMBS_W-1:0]      out_limbs_used,
  output logic [mps_pkg::LIMB_BITS-1:0]    out_neg_inverse,
  output logic [mps_pkg::LIMB_BITS-1:0]    out_rsq_limb0,
  output logic [mps_pkg::LIMB_BITS-1:0]    out_rsq_limb1,
  output logic [mps_pkg::LIMB_BITS-1:0]    out_rsq_limb2
);
  import mps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  state_t               state_r;
  mps_status_t          status_r;
  logic [LIMBS_W-1:0]   limbs_r;
  logic                 out_valid_r;
  mps_status_t          out_status_r;
  logic [LIMBS_W-1:0]   out_limbs_r;
  logic [LIMB_BITS-1:0] out_neg_r;
  logic [MOD_BITS-1:0]  out_rsq_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 nz1;
  logic                 nz2;
  logic [LIMBS_W-1:0]   k_base;
  logic                 top_ones;
  logic                 too_wide;
  logic [LIMBS_W-1:0]   k_used;
  mps_status_t          status_new;
  mps_cmd_t             cmd;
  logic                 eng_busy;
  logic [LIMB_BITS-1:0] eng_neg;
  logic [MOD_BITS-1:0]  eng_rsq;
  logic                 status_ok;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Classify the modulus: limb count, growth on an all-ones top limb, status
  always_comb begin
    nz1      = |in_modulus_limb1;
    nz2      = |in_modulus_limb2;
    k_base   = nz2 ? LIMBS_W'(3) : (nz1 ? LIMBS_W'(2) : LIMBS_W'(1));
    top_ones = nz2 ? &in_modulus_limb2 : (nz1 ? &in_modulus_limb1 : &in_modulus_limb0);
    too_wide = in_oversize || (top_ones && (k_base >= LIMBS_W'(MAX_LIMBS)));
    k_used   = top_ones ? k_base + LIMBS_W'(1) : k_base;
    if (too_wide) begin
      status_new = ST_WIDE;
    end else if (!in_modulus_limb0[0]) begin
      status_new = ST_EVEN;
    end else begin
      status_new = ST_OK;
    end
  end

  assign cmd = '{start: in_acc && (status_new == ST_OK), limbs: k_used};

  mps_serial u_serial (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .modulus     ({in_modulus_limb2, in_modulus_limb1, in_modulus_limb0}),
    .busy        (eng_busy),
    .neg_inverse (eng_neg),
    .rsq         (eng_rsq)
  );

  assign status_ok = (status_r == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Drop valid once taken; the finish state reloads it itself
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            status_r <= status_new;
            limbs_r  <= too_wide ? LIMBS_W'(MAX_LIMBS) : k_used;
            state_r  <= (status_new == ST_OK) ? S_RUN : S_FIN;
          end
        end
        S_RUN: begin
          if (!eng_busy) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // Hold until the output register frees up
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_limbs_r  <= limbs_r;
            out_neg_r    <= status_ok ? eng_neg : '0;
            out_rsq_r    <= status_ok ? eng_rsq : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_limbs_used  = out_limbs_r;
  assign out_neg_inverse = out_neg_r;
  assign out_rsq_limb0   = out_rsq_r[LIMB_BITS-1:0];
  assign out_rsq_limb1   = out_rsq_r[2*LIMB_BITS-1:LIMB_BITS];
  assign out_rsq_limb2   = out_rsq_r[3*LIMB_BITS-1:2*LIMB_BITS];

  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    eng_busy |-> state_r == S_RUN)
    else $error("serial engine busy outside run state");

  a_ok_inverse_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OK) |-> out_neg_r[0])
    else $error("negated inverse of an odd modulus must be odd");

  a_wide_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_WIDE) |-> (out_neg_r == '0 && out_rsq_r == '0))
    else $error("too-wide result carries nonzero payload");

  a_limbs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_limbs_r != '0)
    else $error("limb count of zero reported");

endmodule

### rtl/mps_serial.sv
module mps_serial (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mps_pkg::mps_cmd_t                cmd,
  input  logic [mps_pkg::MOD_BITS-1:0]     modulus,
  output logic                             busy,
  output logic [mps_pkg::LIMB_BITS-1:0]    neg_inverse,
  output logic [mps_pkg::MOD_BITS-1:0]     rsq
);
  import mps_pkg::*;

  logic                 busy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     last_r;
  logic [MOD_BITS-1:0]  n_r;
  logic [MOD_BITS-1:0]  r_r;
  logic [LIMB_BITS-1:0] res_r;
  logic [LIMB_BITS-1:0] y_r;

  logic [MOD_BITS:0]    dbl;
  logic [MOD_BITS+1:0]  diff;
  logic [MOD_BITS-1:0]  r_nxt;
  logic                 inv_bit;
  logic [LIMB_BITS-1:0] inv_sub;
  logic [LIMB_BITS-1:0] res_nxt;
  logic [LIMB_BITS-1:0] y_nxt;
  logic [CNT_W-1:0]     total;

  // Shift r left one bit, subtract n when 2r >= n; one subtractor gives both
  always_comb begin
    dbl   = {r_r, 1'b0};
    diff  = {1'b0, dbl} - {2'b00, n_r};
    r_nxt = diff[MOD_BITS+1] ? dbl[MOD_BITS-1:0] : diff[MOD_BITS-1:0];
  end

  // Serial inverse: clear the low residual bit with the odd modulus, shift right.
  // Starting from all ones yields y with n * y == -1 mod 2^64.
  always_comb begin
    inv_bit = res_r[0];
    inv_sub = res_r - (inv_bit ? n_r[LIMB_BITS-1:0] : '0);
    res_nxt = {1'b0, inv_sub[LIMB_BITS-1:1]};
    y_nxt   = {inv_bit, y_r[LIMB_BITS-1:1]};
  end

  assign total = CNT_W'(cmd.limbs) << STEP_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      last_r <= total - CNT_W'(1);
      n_r    <= modulus;
      r_r    <= (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
      res_r  <= '1;
      y_r    <= '0;
    end else if (busy_r) begin
      r_r   <= r_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r < CNT_W'(LIMB_BITS)) begin
        res_r <= res_nxt;
        y_r   <= y_nxt;
      end
      if (cnt_r == last_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy        = busy_r;
  assign neg_inverse = y_r;
  assign rsq         = r_r;

endmodule

### sim/tb.sv
module tb;
  import mps_pkg::*;

  localparam int LONG_HOLD    = 2000;
  localparam int SETTLE_CYCLES = 2 * LIMB_BITS * MAX_LIMBS + 16;

  typedef struct packed {
    logic [LIMB_BITS-1:0] limb0;
    logic [LIMB_BITS-1:0] limb1;
    logic [LIMB_BITS-1:0] limb2;
    logic                 oversize;
  } modulus_item_t;

  typedef struct packed {
    mps_status_t          status;
    logic [LIMBS_W-1:0]   limbs_used;
    logic [LIMB_BITS-1:0] neg_inverse;
    logic [LIMB_BITS-1:0] rsq_limb0;
    logic [LIMB_BITS-1:0] rsq_limb1;
    logic [LIMB_BITS-1:0] rsq_limb2;
  } setup_result_t;

  class setup_scoreboard;
    setup_result_t expected_q[$];
    int mismatches;
    int checked;
    int n_ok;
    int n_wide;
    int n_even;

    function setup_result_t predict_setup(modulus_item_t m);
      setup_result_t res;
      logic [LIMB_BITS-1:0] limbs [MAX_LIMBS];
      logic [LIMB_BITS-1:0] inv;
      logic [MOD_BITS:0]    n_wide;
      logic [MOD_BITS:0]    rem;
      int k;
      res = '0;
      limbs[0] = m.limb0;
      limbs[1] = m.limb1;
      limbs[2] = m.limb2;
      k = 1;
      for (int i = 0; i < MAX_LIMBS; i++)
        if (limbs[i] != 0) k = i + 1;
      // an all-ones top limb needs one more limb; no room left means too wide
      if (m.oversize || (limbs[k-1] == '1 && k >= MAX_LIMBS)) begin
        res.status = ST_WIDE;
        res.limbs_used = LIMBS_W'(MAX_LIMBS);
        return res;
      end
      if (limbs[k-1] == '1) k++;
      res.limbs_used = LIMBS_W'(k);
      if (!m.limb0[0]) begin
        res.status = ST_EVEN;
        return res;
      end
      // x = a is right to 3 bits for odd a; each step doubles the correct bits
      inv = m.limb0;
      repeat (5) inv = inv * (64'd2 - m.limb0 * inv);
      res.status = ST_OK;
      res.neg_inverse = -inv;
      n_wide = {1'b0, m.limb2, m.limb1, m.limb0};
      rem = 1;
      if (rem >= n_wide) rem = rem - n_wide;
      for (int j = 0; j < 2 * LIMB_BITS * k; j++) begin
        rem = rem << 1;
        if (rem >= n_wide) rem = rem - n_wide;
      end
      res.rsq_limb0 = rem[LIMB_BITS-1:0];
      res.rsq_limb1 = rem[2*LIMB_BITS-1:LIMB_BITS];
      res.rsq_limb2 = rem[3*LIMB_BITS-1:2*LIMB_BITS];
      return res;
    endfunction

    function void note_modulus(modulus_item_t m);
      setup_result_t want;
      want = predict_setup(m);
      case (want.status)
        ST_OK:   n_ok++;
        ST_WIDE: n_wide++;
        default: n_even++;
      endcase
      expected_q.push_back(want);
    endfunction

    function void check_result(setup_result_t got);
      setup_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with no modulus pending: status=%0d k=%0d",
                   got.status, got.limbs_used);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.limbs_used !== want.limbs_used ||
          got.neg_inverse !== want.neg_inverse || got.rsq_limb0 !== want.rsq_limb0 ||
          got.rsq_limb1 !== want.rsq_limb1 || got.rsq_limb2 !== want.rsq_limb2) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d: status %0d/%0d k %0d/%0d ninv %h/%h",
                   checked, want.status, got.status, want.limbs_used,
                   got.limbs_used, want.neg_inverse, got.neg_inverse);
          $display("  rsq expected %h_%h_%h got %h_%h_%h",
                   want.rsq_limb2, want.rsq_limb1, want.rsq_limb0,
                   got.rsq_limb2, got.rsq_limb1, got.rsq_limb0);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [LIMB_BITS-1:0] in_modulus_limb0;
  logic [LIMB_BITS-1:0] in_modulus_limb1;
  logic [LIMB_BITS-1:0] in_modulus_limb2;
  logic                 in_oversize;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  out_status;
  logic [LIMBS_W-1:0]   out_limbs_used;
  logic [LIMB_BITS-1:0] out_neg_inverse;
  logic [LIMB_BITS-1:0] out_rsq_limb0;
  logic [LIMB_BITS-1:0] out_rsq_limb1;
  logic [LIMB_BITS-1:0] out_rsq_limb2;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int holds_done;

  setup_scoreboard sb = new;

  montgomery_parameter_setup_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_modulus_limb0 (in_modulus_limb0),
    .in_modulus_limb1 (in_modulus_limb1),
    .in_modulus_limb2 (in_modulus_limb2),
    .in_oversize      (in_oversize),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_limbs_used   (out_limbs_used),
    .out_neg_inverse  (out_neg_inverse),
    .out_rsq_limb0    (out_rsq_limb0),
    .out_rsq_limb1    (out_rsq_limb1),
    .out_rsq_limb2    (out_rsq_limb2)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    holds_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    setup_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status      = mps_status_t'(out_status);
      got.limbs_used  = out_limbs_used;
      got.neg_inverse = out_neg_inverse;
      got.rsq_limb0   = out_rsq_limb0;
      got.rsq_limb1   = out_rsq_limb1;
      got.rsq_limb2   = out_rsq_limb2;
      sb.check_result(got);
    end
  end

  function automatic modulus_item_t mod_item(logic [LIMB_BITS-1:0] l2, l1, l0,
                                             logic ovs);
    modulus_item_t m;
    m.limb0 = l0;
    m.limb1 = l1;
    m.limb2 = l2;
    m.oversize = ovs;
    return m;
  endfunction

  // entered and left at a falling edge
  task automatic send_modulus(input modulus_item_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_modulus_limb0 <= m.limb0;
    in_modulus_limb1 <= m.limb1;
    in_modulus_limb2 <= m.limb2;
    in_oversize      <= m.oversize;
    do @(posedge clk); while (in_stall);
    sb.note_modulus(m);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    modulus_item_t m;
    int kind;
    repeat (count) begin
      kind = $urandom_range(99);
      m.limb0 = {$urandom, $urandom};
      m.limb1 = {$urandom, $urandom};
      m.limb2 = {$urandom, $urandom};
      m.oversize = 1'b0;
      if (kind < 58) begin
        m.limb1 = '0;
        m.limb2 = '0;
        m.limb0[0] = 1'b1;
      end else if (kind < 73) begin
        m.limb2 = '0;
        m.limb0[0] = 1'b1;
      end else if (kind < 80) begin
        m.limb0[0] = 1'b1;
      end else if (kind < 86) begin
        // even modulus of any size
        m.limb0[0] = 1'b0;
        if ($urandom_range(1)) m.limb2 = '0;
        if ($urandom_range(1)) m.limb1 = '0;
        if ($urandom_range(3) == 0) m.limb0 = '0;
      end else if (kind < 91) begin
        m.oversize = 1'b1;
      end else if (kind < 95) begin
        m.limb2 = '1;
      end else begin
        // all-ones top limb that forces one extra limb
        m.limb2 = '0;
        if ($urandom_range(1)) begin
          m.limb1 = '0;
          m.limb0 = '1;
        end else begin
          m.limb1 = '1;
          m.limb0[0] = $urandom_range(3) != 0;
        end
      end
      send_modulus(m);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_modulus_limb0 = '0;
    in_modulus_limb1 = '0;
    in_modulus_limb2 = '0;
    in_oversize = 1'b0;
    send_idle_pct = 32;
    recv_idle_pct = 73;
    hold_requests = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_modulus(mod_item('0, '0, '0, 1'b0));
    send_modulus(mod_item('0, '0, 64'd1, 1'b0));
    send_modulus(mod_item('0, '0, 64'd3, 1'b0));
    send_modulus(mod_item('0, '0, '1, 1'b0));
    send_modulus(mod_item('0, '1, '1, 1'b0));
    send_modulus(mod_item('1, '0, 64'd1, 1'b0));
    send_modulus(mod_item('0, '0, 64'd1, 1'b1));
    send_modulus(mod_item('0, '0, '0, 1'b1));
    send_modulus(mod_item('1, '1, '1, 1'b1));
    send_modulus(mod_item('0, 64'd1, 64'd1, 1'b0));
    send_modulus(mod_item(64'd1, '0, 64'd1, 1'b0));
    send_modulus(mod_item(64'hFFFF_FFFF_FFFF_FFFE, '1, '1, 1'b0));
    send_modulus(mod_item('0, 64'd5, 64'd2, 1'b0));
    send_modulus(mod_item(64'd7, '0, '0, 1'b0));
    send_modulus(mod_item('0, '1, 64'd2, 1'b0));
    send_modulus(mod_item('0, '0, 64'h8000_0000_0000_0001, 1'b0));
    send_modulus(mod_item('0, 64'h8000_0000_0000_0000, '1, 1'b0));
    send_modulus(mod_item('0, '0, 64'hFFFF_FFFF_FFFF_FFFD, 1'b0));
    send_modulus(mod_item(64'h7FFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
                          64'hFEDC_BA98_7654_3211, 1'b0));
    wait_drained();

    // hold the output off for a long stretch while moduli keep coming
    @(posedge clk);
    hold_requests++;
    @(negedge clk);
    run_random(12);
    wait_drained();

    run_random(320);
    wait_drained();

    send_idle_pct = 73;
    recv_idle_pct = 32;
    run_random(330);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(330);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d moduli: %0d odd, %0d too wide, %0d even, with stalls on both sides",
             sb.n_ok + sb.n_wide + sb.n_even, sb.n_ok, sb.n_wide, sb.n_even);
    $display("Checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### montgomery_parameter_setup_top.f
rtl/mps_pkg.sv
rtl/mps_serial.sv
rtl/montgomery_parameter_setup_top.sv
sim/tb.sv
